// ===== rtl/core/laplacian_3x3_edge_filter_defines.svh =====
// Assertion macros shared by the edge filter RTL.
`ifndef LAPLACIAN_3X3_EDGE_FILTER_DEFINES_SVH
`define LAPLACIAN_3X3_EDGE_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define LAP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LAP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LAP_ASSERT(label, clk, rst_n, prop, msg)
`define LAP_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/lap_pkg.sv =====
// Shared constants and types of the 3x3 Laplacian edge filter.
package lap_pkg;

  localparam int LAP_MAX_WIDTH = 8192;
  localparam int LAP_PIX_W     = 8;
  localparam int LAP_ROW_W     = 16;
  localparam int LAP_WIDTH_W   = 14;
  localparam int LAP_HEIGHT_W  = 16;
  localparam int LAP_DATA_W    = 16;
  localparam int LAP_IDX_W     = 2;
  localparam int LAP_RESET_DIM = 6000;
  localparam int LAP_MIN_DIM   = 3;
  localparam int LAP_GAIN_SH   = 3;
  localparam int LAP_SUM_W     = LAP_PIX_W + LAP_GAIN_SH;

  typedef enum logic [LAP_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } lap_reg_e;

  typedef struct packed {
    logic emit;
    logic last;
  } lap_flags_t;

endpackage

// ===== rtl/core/lap_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lap_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lap_front.sv =====
// Input stage: frame registers, raster counters and line store read issue.
`include "laplacian_3x3_edge_filter_defines.svh"
module lap_front #(
  parameter int MaxWidth = lap_pkg::LAP_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [lap_pkg::LAP_IDX_W-1:0]  cfg_index_i,
  input  logic [lap_pkg::LAP_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lap_pkg::LAP_PIX_W-1:0]  pixel_in_i,
  output logic                           rd_en_o,
  output logic [$clog2(MaxWidth)-1:0]    rd_addr_o,
  output logic                           s1_valid_o,
  input  logic                           s1_ready_i,
  output lap_pkg::lap_flags_t            s1_flags_o,
  output logic [lap_pkg::LAP_PIX_W-1:0]  s1_pix_o,
  output logic [$clog2(MaxWidth)-1:0]    s1_addr_o,
  output logic [lap_pkg::LAP_ROW_W-1:0]  s1_row_o,
  output logic [$clog2(MaxWidth)-1:0]    s1_col_o
);
  import lap_pkg::*;

  localparam int ColW    = $clog2(MaxWidth);
  localparam int EffW    = LAP_WIDTH_W + 1;
  localparam int ResetW  = (LAP_RESET_DIM > MaxWidth) ? MaxWidth : LAP_RESET_DIM;

  logic [ColW-1:0]         w_last_q, w_last_d;
  logic [LAP_ROW_W-1:0]    h_last_q, h_last_d;
  logic [ColW-1:0]         col_q, col_d;
  logic [LAP_ROW_W-1:0]    row_q, row_d;
  logic                    s1_valid_q, s1_valid_d;
  lap_flags_t              s1_flags_q;
  logic [LAP_PIX_W-1:0]    s1_pix_q;
  logic [ColW-1:0]         s1_addr_q;
  logic [LAP_ROW_W-1:0]    s1_row_q;
  logic [ColW-1:0]         s1_col_q;
  logic [EffW-1:0]         w_eff;
  logic [LAP_HEIGHT_W-1:0] h_eff;
  logic                    accept;
  logic                    wr_width;
  logic                    wr_height;
  logic                    col_end;
  logic                    row_end;

  assign wr_width  = cfg_valid_i && (cfg_index_i == REG_FRAME_WIDTH);
  assign wr_height = cfg_valid_i && (cfg_index_i == REG_FRAME_HEIGHT);

  always_comb begin
    w_eff = {1'b0, cfg_data_i[LAP_WIDTH_W-1:0]};
    if (w_eff < EffW'(LAP_MIN_DIM)) begin
      w_eff = EffW'(LAP_MIN_DIM);
    end
    if (w_eff > EffW'(MaxWidth)) begin
      w_eff = EffW'(MaxWidth);
    end
    h_eff = cfg_data_i[LAP_HEIGHT_W-1:0];
    if (h_eff < LAP_HEIGHT_W'(LAP_MIN_DIM)) begin
      h_eff = LAP_HEIGHT_W'(LAP_MIN_DIM);
    end
  end

  assign w_last_d = wr_width ? ColW'(w_eff - EffW'(1)) : w_last_q;
  assign h_last_d = wr_height ? LAP_ROW_W'(h_eff - LAP_HEIGHT_W'(1)) : h_last_q;

  assign in_stall_o = s1_valid_q && !s1_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign col_end    = (col_q == w_last_q);
  assign row_end    = (row_q == h_last_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (wr_width || wr_height) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + LAP_ROW_W'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q   <= ColW'(ResetW - 1);
      h_last_q   <= LAP_ROW_W'(LAP_RESET_DIM - 1);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      w_last_q   <= w_last_d;
      h_last_q   <= h_last_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q.emit <= (row_q >= LAP_ROW_W'(2)) && (col_q >= ColW'(2));
      s1_flags_q.last <= row_end && col_end;
      s1_pix_q        <= pixel_in_i;
      s1_addr_q       <= col_q;
      s1_row_q        <= row_q - LAP_ROW_W'(1);
      s1_col_q        <= col_q - ColW'(1);
    end
  end

  assign rd_en_o    = accept;
  assign rd_addr_o  = col_q;
  assign s1_valid_o = s1_valid_q;
  assign s1_flags_o = s1_flags_q;
  assign s1_pix_o   = s1_pix_q;
  assign s1_addr_o  = s1_addr_q;
  assign s1_row_o   = s1_row_q;
  assign s1_col_o   = s1_col_q;

  `LAP_ASSERT(a_col_in_frame, clk_i, rst_ni, col_q <= w_last_q, "column beyond frame width")
  `LAP_ASSERT(a_row_in_frame, clk_i, rst_ni, row_q <= h_last_q, "row beyond frame height")

endmodule

// ===== rtl/core/lap_win.sv =====
// Line store write-back, 3x3 window, Laplacian kernel and output register.
`include "laplacian_3x3_edge_filter_defines.svh"
module lap_win #(
  parameter int MaxWidth = lap_pkg::LAP_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s1_valid_i,
  output logic                           s1_ready_o,
  input  lap_pkg::lap_flags_t            s1_flags_i,
  input  logic [lap_pkg::LAP_PIX_W-1:0]  s1_pix_i,
  input  logic [$clog2(MaxWidth)-1:0]    s1_addr_i,
  input  logic [lap_pkg::LAP_ROW_W-1:0]  s1_row_i,
  input  logic [$clog2(MaxWidth)-1:0]    s1_col_i,
  input  logic [2*lap_pkg::LAP_PIX_W-1:0] rd_data_i,
  output logic                           wr_en_o,
  output logic [$clog2(MaxWidth)-1:0]    wr_addr_o,
  output logic [2*lap_pkg::LAP_PIX_W-1:0] wr_data_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lap_pkg::LAP_PIX_W-1:0]  pixel_out_o,
  output logic [lap_pkg::LAP_ROW_W-1:0]  out_row_o,
  output logic [$clog2(MaxWidth)-1:0]    out_col_o,
  output logic                           frame_last_o
);
  import lap_pkg::*;

  localparam int ColW = $clog2(MaxWidth);

  logic [LAP_PIX_W-1:0] win_q [3][3];
  logic [LAP_PIX_W-1:0] top_px, mid_px;
  logic                 s2_valid_q;
  lap_flags_t           s2_flags_q;
  logic [LAP_ROW_W-1:0] s2_row_q;
  logic [ColW-1:0]      s2_col_q;
  logic                 out_valid_q;
  logic [LAP_PIX_W-1:0] out_pix_q;
  logic [LAP_ROW_W-1:0] out_row_q;
  logic [ColW-1:0]      out_col_q;
  logic                 out_last_q;
  logic                 out_ready;
  logic                 s2_move;
  logic                 s2_free;
  logic                 s1_take;
  logic                 out_load;
  logic [LAP_SUM_W-1:0] pos_sum, neg_sum, diff;
  logic [LAP_PIX_W-1:0] lap_px;

  assign top_px = rd_data_i[2*LAP_PIX_W-1:LAP_PIX_W];
  assign mid_px = rd_data_i[LAP_PIX_W-1:0];

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_move    = s2_valid_q && (!s2_flags_q.emit || out_ready);
  assign s2_free    = !s2_valid_q || s2_move;
  assign s1_take    = s1_valid_i && s2_free;
  assign out_load   = s2_move && s2_flags_q.emit;
  assign s1_ready_o = s2_free;

  assign wr_en_o   = s1_take;
  assign wr_addr_o = s1_addr_i;
  assign wr_data_o = {mid_px, s1_pix_i};

  always_comb begin
    pos_sum = {win_q[1][1], LAP_GAIN_SH'(0)};
    neg_sum = LAP_SUM_W'(win_q[0][0]) + LAP_SUM_W'(win_q[0][1]) + LAP_SUM_W'(win_q[0][2])
            + LAP_SUM_W'(win_q[1][0]) + LAP_SUM_W'(win_q[1][2])
            + LAP_SUM_W'(win_q[2][0]) + LAP_SUM_W'(win_q[2][1]) + LAP_SUM_W'(win_q[2][2]);
    diff    = pos_sum - neg_sum;
    if (neg_sum > pos_sum) begin
      lap_px = '0;
    end else if (diff > LAP_SUM_W'(255)) begin
      lap_px = '1;
    end else begin
      lap_px = diff[LAP_PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_take) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[0][2] <= top_px;
        win_q[1][2] <= mid_px;
        win_q[2][2] <= s1_pix_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s2_flags_q <= s1_flags_i;
      s2_row_q   <= s1_row_i;
      s2_col_q   <= s1_col_i;
    end
    if (out_load) begin
      out_pix_q  <= lap_px;
      out_row_q  <= s2_row_q;
      out_col_q  <= s2_col_q;
      out_last_q <= s2_flags_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_pix_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

  `LAP_ASSERT(a_s2_held, clk_i, rst_ni, s2_valid_q && s2_flags_q.emit && !out_ready |=> s2_valid_q, "result dropped while output stalled")

endmodule

// ===== rtl/core/laplacian_3x3_edge_filter.sv =====
// Top level of the streaming 3x3 Laplacian edge filter.
// Takes one 8-bit pixel per clock in raster order, sustained while
// in_stall_o is low, and returns one filtered value per interior pixel
// through the s1, window and output registers. Rows r-2 and r-1 live in a
// single MaxWidth x 16 line store RAM read on transfer of a pixel and
// written back as it leaves s1; the line store is not cleared after reset.
// Writing either frame register restarts the frame at row 0, column 0.
`include "laplacian_3x3_edge_filter_defines.svh"
module laplacian_3x3_edge_filter #(
  parameter int MaxWidth = lap_pkg::LAP_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lap_pkg::LAP_IDX_W-1:0]  cfg_index_i,
  input  logic [lap_pkg::LAP_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lap_pkg::LAP_PIX_W-1:0]  pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lap_pkg::LAP_PIX_W-1:0]  pixel_out_o,
  output logic [lap_pkg::LAP_ROW_W-1:0]  out_row_o,
  output logic [$clog2(MaxWidth)-1:0]    out_col_o,
  output logic                           frame_last_o
);
  import lap_pkg::*;

  localparam int ColW = $clog2(MaxWidth);

  logic                     rd_en;
  logic [ColW-1:0]          rd_addr;
  logic [2*LAP_PIX_W-1:0]   rd_data;
  logic                     wr_en;
  logic [ColW-1:0]          wr_addr;
  logic [2*LAP_PIX_W-1:0]   wr_data;
  logic                     s1_valid;
  logic                     s1_ready;
  lap_flags_t               s1_flags;
  logic [LAP_PIX_W-1:0]     s1_pix;
  logic [ColW-1:0]          s1_addr;
  logic [LAP_ROW_W-1:0]     s1_row;
  logic [ColW-1:0]          s1_col;

  assign cfg_ready_o = 1'b1;

  lap_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_in_i (pixel_in_i),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_flags_o (s1_flags),
    .s1_pix_o   (s1_pix),
    .s1_addr_o  (s1_addr),
    .s1_row_o   (s1_row),
    .s1_col_o   (s1_col)
  );

  lap_ram #(.Width(2*LAP_PIX_W), .Depth(MaxWidth)) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  lap_win #(.MaxWidth(MaxWidth)) u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_flags_i  (s1_flags),
    .s1_pix_i    (s1_pix),
    .s1_addr_i   (s1_addr),
    .s1_row_i    (s1_row),
    .s1_col_i    (s1_col),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_last_o(frame_last_o)
  );

  `LAP_ASSERT_NEVER(a_no_rw_clash, clk_i, rst_ni, rd_en && wr_en && (rd_addr == wr_addr), "line store read and write hit the same entry")
  `LAP_ASSERT(a_write_follows_read, clk_i, rst_ni, wr_en |-> s1_valid, "line store written without a pending pixel")

endmodule
